FILE: hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit block allocator
// Cell count, owner word, command and status codes, controller states.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int CELLS = 128;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);

  typedef logic [15:0] owner_t;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_DEFRAG = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NULL      = 2'd1,
    ST_ILLEGAL   = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_STAMP,
    S_ERASE,
    S_PACK,
    S_EMIT
  } state_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic shift;
    logic compact;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa_cmd_if / ffa_res_if: valid/ready channels of the allocator
// A transfer happens on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ffa_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] amount_or_id;
  modport source (output valid, output action, output amount_or_id, input ready);
  modport sink   (input valid, input action, input amount_or_id, output ready);
endinterface

interface ffa_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] block_id;
  modport source (output valid, output status, output block_id, input ready);
  modport sink   (input valid, input status, input block_id, output ready);
endinterface

FILE: hw/rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit cell allocator with erase and packing
// One command at a time. An alloc runs a scan pass, then a stamp pass that is
// skipped when no run fits; erase runs one pass, then an emit step when the id
// owns no cell; defragment packs in one pass; failed argument checks go to the
// emit step. A result still held by the receiver stalls the next result there.
// Synchronous reset frees every cell and sets the next id to one.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic      clk,
  input  logic      rst,
  ffa_cmd_if.sink   cmd,
  ffa_res_if.source res
);

  ffa_pkg::owner_t    value [ffa_pkg::CELLS];
  logic               hole  [ffa_pkg::CELLS];
  ffa_pkg::owner_t    tail;
  ffa_pkg::owner_t    top_in;
  ffa_pkg::cell_ctl_t ctl;

  assign top_in = ctl.compact ? '0 : tail;

  for (genvar i = 0; i < ffa_pkg::CELLS; i++) begin : g_row
    ffa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .nbr      ((i == ffa_pkg::CELLS - 1) ? top_in : value[(i + 1) % ffa_pkg::CELLS]),
      .hole_in  ((i == 0) ? 1'b0 : hole[(i + ffa_pkg::CELLS - 1) % ffa_pkg::CELLS]),
      .value    (value[i]),
      .hole_out (hole[i])
    );
  end

  ffa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .res  (res),
    .head (value[0]),
    .tail (tail),
    .ctl  (ctl)
  );

endmodule

FILE: hw/rtl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell: one owner cell of the row
// Shifts toward the head, or collapses over the first free cell when packing.
// ----------------------------------------------------------------------------
module ffa_cell (
  input  logic                clk,
  input  logic                rst,
  input  ffa_pkg::cell_ctl_t  ctl,
  input  ffa_pkg::owner_t     nbr,
  input  logic                hole_in,
  output ffa_pkg::owner_t     value,
  output logic                hole_out
);

  logic take;

  // a free cell here or below pulls the upper neighbor down
  assign take     = hole_in | (value == '0);
  assign hole_out = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctl.shift || (ctl.compact && take)) begin
      value <= nbr;
    end
  end

endmodule

FILE: hw/rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl: command sequencer of the allocator
// Watches the head of the rotating row, rewrites the tail, issues results.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic               clk,
  input  logic               rst,
  ffa_cmd_if.sink            cmd,
  ffa_res_if.source          res,
  input  ffa_pkg::owner_t    head,
  output ffa_pkg::owner_t    tail,
  output ffa_pkg::cell_ctl_t ctl
);

  ffa_pkg::state_t  state, state_next;
  logic [ffa_pkg::IDX_W-1:0] cnt, hit_idx;
  logic [ffa_pkg::CNT_W-1:0] run, want;
  logic             found;
  ffa_pkg::owner_t  arg, next_id;
  ffa_pkg::status_t pend_status;
  ffa_pkg::owner_t  pend_id;
  logic             out_valid;
  ffa_pkg::status_t out_status;
  ffa_pkg::owner_t  out_id;

  logic last, accept, bad_alloc, run_hit, in_range, emit_go;
  logic [ffa_pkg::CNT_W-1:0] run_inc;
  logic [ffa_pkg::CNT_W:0]   upper;

  assign last      = cnt == ffa_pkg::IDX_W'(ffa_pkg::CELLS - 1);
  assign accept    = cmd.valid && cmd.ready;
  assign bad_alloc = (cmd.amount_or_id == '0) || (next_id == '0) ||
                     (cmd.amount_or_id > 16'(ffa_pkg::CELLS));
  assign run_inc   = run + 1'b1;
  assign run_hit   = !found && (head == '0) && (run_inc == want);
  // stamp cells hit_idx-want+1 .. hit_idx
  assign upper     = {1'b0, ffa_pkg::CNT_W'(cnt)} + {1'b0, want};
  assign in_range  = (cnt <= hit_idx) && (upper > {1'b0, ffa_pkg::CNT_W'(hit_idx)});
  assign emit_go   = !out_valid || res.ready;

  assign cmd.ready    = state == ffa_pkg::S_IDLE;
  assign res.valid    = out_valid;
  assign res.status   = out_status;
  assign res.block_id = out_id;

  always_comb begin
    state_next = state;
    unique case (state)
      ffa_pkg::S_IDLE: begin
        if (accept) begin
          unique case (ffa_pkg::action_t'(cmd.action))
            ffa_pkg::ACT_ALLOC:  state_next = bad_alloc ? ffa_pkg::S_EMIT : ffa_pkg::S_SCAN;
            ffa_pkg::ACT_ERASE:  state_next = (cmd.amount_or_id == '0) ? ffa_pkg::S_EMIT
                                                                      : ffa_pkg::S_ERASE;
            ffa_pkg::ACT_DEFRAG: state_next = ffa_pkg::S_PACK;
            default:             state_next = ffa_pkg::S_IDLE;
          endcase
        end
      end
      ffa_pkg::S_SCAN: begin
        if (last) state_next = (found || run_hit) ? ffa_pkg::S_STAMP : ffa_pkg::S_EMIT;
      end
      ffa_pkg::S_STAMP: if (last) state_next = ffa_pkg::S_EMIT;
      ffa_pkg::S_ERASE: begin
        if (last) state_next = (found || head == arg) ? ffa_pkg::S_IDLE : ffa_pkg::S_EMIT;
      end
      ffa_pkg::S_PACK:  if (last) state_next = ffa_pkg::S_IDLE;
      ffa_pkg::S_EMIT:  if (emit_go) state_next = ffa_pkg::S_IDLE;
      default:          state_next = ffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    tail = head;
    unique case (state)
      ffa_pkg::S_SCAN:  ctl.shift = 1'b1;
      ffa_pkg::S_STAMP: begin
        ctl.shift = 1'b1;
        if (in_range) tail = next_id;
      end
      ffa_pkg::S_ERASE: begin
        ctl.shift = 1'b1;
        if (head == arg) tail = '0;
      end
      ffa_pkg::S_PACK:  ctl.compact = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffa_pkg::S_IDLE;
      cnt        <= '0;
      found      <= 1'b0;
      run        <= '0;
      next_id    <= 16'd1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ffa_pkg::S_EMIT && emit_go) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_id     <= pend_id;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ffa_pkg::S_IDLE: begin
          cnt   <= '0;
          found <= 1'b0;
          run   <= '0;
          arg   <= cmd.amount_or_id;
          want  <= ffa_pkg::CNT_W'(cmd.amount_or_id);
          pend_id <= '0;
          pend_status <= (ffa_pkg::action_t'(cmd.action) == ffa_pkg::ACT_ALLOC)
                         ? ffa_pkg::ST_NULL : ffa_pkg::ST_ILLEGAL;
        end
        ffa_pkg::S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (!found) begin
            run <= (head == '0) ? run_inc : '0;
            if (run_hit) begin
              found   <= 1'b1;
              hit_idx <= cnt;
            end
          end
        end
        ffa_pkg::S_STAMP: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            next_id     <= next_id + 1'b1;
            pend_status <= ffa_pkg::ST_ALLOCATED;
            pend_id     <= next_id;
          end
        end
        ffa_pkg::S_ERASE: begin
          cnt <= cnt + 1'b1;
          if (head == arg) found <= 1'b1;
        end
        ffa_pkg::S_PACK: cnt <= cnt + 1'b1;
        default: ;
      endcase
    end
  end

endmodule
